// ===== hw/rtl/fig_pkg.sv =====
// Shared types and constants for the force impulse grasp detector.
`default_nettype none

package fig_pkg;

    // Operation codes carried in the input beat
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Field widths
    localparam int FORCE_W = 16;
    localparam int MAG_W   = 16;
    localparam int THR_W   = 16;
    localparam int SQ_W    = 32;

    // Reset value of the impulse threshold: 0.8 N in Q8.8
    localparam logic [THR_W-1:0] THR_RESET = 16'd205;

    typedef struct packed {
        logic                      operation;
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic signed [FORCE_W-1:0] force_z;
    } fig_in_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             window_full;
        logic             grasp_detected;
    } fig_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/force_impulse_grasp_detector_top.sv =====
// Top level of the force impulse grasp detector: bit-serial squares, digit-serial root, history.
`default_nettype none

// Each force sample beat passes through a shift-and-add squarer (one multiplier bit of
// all three axes per cycle), then a restoring square root (one root bit per cycle),
// then a finish step that updates the magnitude history and forms the flags. A clear
// beat skips the squarer and the root and goes straight to the finish step. The input
// is ready again the cycle after a result is loaded, so a new beat is taken only once
// the previous one is through. While the output register still holds a result that is
// not being taken, the core waits in its last step and the input stays stalled.
// One beat is in flight at a time; the next beat is taken as soon as the previous
// result sits in the output register, even if that result has not been taken yet.
// The impulse threshold may be rewritten only while no beat is in flight.
module force_impulse_grasp_detector_top
    import fig_pkg::*;
#(
    parameter int WINDOW_SIZE = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // Configuration
    input  wire logic             cfg_wr_en,
    input  wire logic [THR_W-1:0] cfg_wr_data,
    // Input channel
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire fig_in_t          s_payload,
    // Result channel
    output logic                  m_valid,
    input  wire logic             m_ready,
    output fig_out_t              m_payload
);

    localparam int FILL_W = $clog2(WINDOW_SIZE + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_SIZE);
    localparam int ABS_W  = FORCE_W;
    localparam int REM_W  = MAG_W + 1;
    localparam int CNT_W  = $clog2(ABS_W);

    // State codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SQUARE = 2'd1;
    localparam logic [1:0] ST_ROOT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              clear_reg, clear_next;
    logic [THR_W-1:0]  thr_reg;

    // Squarer operands: multiplicands shift left, multipliers shift right
    logic [SQ_W-1:0]   mcx_reg, mcy_reg, mcz_reg;
    logic [SQ_W-1:0]   mcx_next, mcy_next, mcz_next;
    logic [ABS_W-1:0]  mpx_reg, mpy_reg, mpz_reg;
    logic [ABS_W-1:0]  mpx_next, mpy_next, mpz_next;

    // Sum of squares, later shifted out two bits per root step
    logic [SQ_W-1:0]   rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0]  root_reg, root_next;

    // History and fill count
    logic [MAG_W-1:0]  rec0_reg, rec1_reg;
    logic [FILL_W-1:0] fill_reg;

    logic              m_valid_reg;
    fig_out_t          m_payload_reg;

    logic [ABS_W-1:0]  abs_x, abs_y, abs_z;
    logic [SQ_W-1:0]   pp_x, pp_y, pp_z;
    logic [REM_W+1:0]  rem_shift, trial, rem_diff;
    logic              root_ge;
    logic              out_free;
    logic              accept;
    logic [FILL_W-1:0] fill_inc;
    logic              full_now;
    logic signed [MAG_W+2:0] d2;
    logic [MAG_W+2:0]  d2_abs;
    logic              grasp_now;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Take absolute values of the axes; -32768 maps to 32768 unsigned
    assign abs_x = s_payload.force_x[FORCE_W-1] ? ABS_W'(-s_payload.force_x)
                                                : ABS_W'(s_payload.force_x);
    assign abs_y = s_payload.force_y[FORCE_W-1] ? ABS_W'(-s_payload.force_y)
                                                : ABS_W'(s_payload.force_y);
    assign abs_z = s_payload.force_z[FORCE_W-1] ? ABS_W'(-s_payload.force_z)
                                                : ABS_W'(s_payload.force_z);

    // Partial products for the current multiplier bit
    assign pp_x = mpx_reg[0] ? mcx_reg : '0;
    assign pp_y = mpy_reg[0] ? mcy_reg : '0;
    assign pp_z = mpz_reg[0] ? mcz_reg : '0;

    // One restoring root step: bring down two radicand bits, try root*4+1
    assign rem_shift = {rem_reg, rad_reg[SQ_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign root_ge   = (rem_shift >= trial);
    assign rem_diff  = rem_shift - trial;

    // History update and second difference, newest magnitude is root_reg
    assign fill_inc  = (fill_reg < FILL_MAX) ? fill_reg + 1'b1 : fill_reg;
    assign full_now  = (fill_inc == FILL_MAX);
    assign d2        = $signed({2'b00, rec0_reg, 1'b0})
                     - $signed({3'b000, root_reg})
                     - $signed({3'b000, rec1_reg});
    assign d2_abs    = d2[MAG_W+2] ? (MAG_W+3)'(-d2) : (MAG_W+3)'(d2);
    assign grasp_now = full_now && (d2_abs > {3'b000, thr_reg});

    // Sequence one beat through square, root and finish
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        clear_next = clear_reg;
        mcx_next   = mcx_reg;
        mcy_next   = mcy_reg;
        mcz_next   = mcz_reg;
        mpx_next   = mpx_reg;
        mpy_next   = mpy_reg;
        mpz_next   = mpz_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    clear_next = (s_payload.operation == OP_CLEAR);
                    mcx_next   = SQ_W'(abs_x);
                    mcy_next   = SQ_W'(abs_y);
                    mcz_next   = SQ_W'(abs_z);
                    mpx_next   = abs_x;
                    mpy_next   = abs_y;
                    mpz_next   = abs_z;
                    rad_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = (s_payload.operation == OP_CLEAR) ? ST_FINISH : ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                rad_next = rad_reg + pp_x + pp_y + pp_z;
                mcx_next = {mcx_reg[SQ_W-2:0], 1'b0};
                mcy_next = {mcy_reg[SQ_W-2:0], 1'b0};
                mcz_next = {mcz_reg[SQ_W-2:0], 1'b0};
                mpx_next = {1'b0, mpx_reg[ABS_W-1:1]};
                mpy_next = {1'b0, mpy_reg[ABS_W-1:1]};
                mpz_next = {1'b0, mpz_reg[ABS_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ABS_W - 1)) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                rad_next  = {rad_reg[SQ_W-3:0], 2'b00};
                rem_next  = root_ge ? rem_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
                root_next = {root_reg[MAG_W-2:0], root_ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAG_W - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers, threshold, history and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            clear_reg   <= 1'b0;
            thr_reg     <= THR_RESET;
            rec0_reg    <= '0;
            rec1_reg    <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            clear_reg  <= clear_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
                if (clear_reg) begin
                    rec0_reg <= '0;
                    rec1_reg <= '0;
                    fill_reg <= '0;
                end else begin
                    rec0_reg <= root_reg;
                    rec1_reg <= rec0_reg;
                    fill_reg <= fill_inc;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        mcx_reg  <= mcx_next;
        mcy_reg  <= mcy_next;
        mcz_reg  <= mcz_next;
        mpx_reg  <= mpx_next;
        mpy_reg  <= mpy_next;
        mpz_reg  <= mpz_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        if (state_reg == ST_FINISH && out_free) begin
            if (clear_reg) begin
                m_payload_reg <= '0;
            end else begin
                m_payload_reg.magnitude      <= root_reg;
                m_payload_reg.window_full    <= full_now;
                m_payload_reg.grasp_detected <= grasp_now;
            end
        end
    end

endmodule

`default_nettype wire
